>>> rtl/core/lcs_pkg.sv
package lcs_pkg;

    // field widths fixed by the interface
    localparam int PIX_W          = 8;
    localparam int FRAME_PIXELS_W = 17;

    // default frame store depth
    localparam int DEFAULT_MAX_PIXELS = 65536;

    // register reset value
    localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RESET = 17'd65536;

    // grey level limits
    localparam logic [PIX_W-1:0] LEVEL_MIN = 8'd0;
    localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

    // request kinds carried on tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_LOAD,
        ST_READ,
        ST_FETCH,
        ST_DIV,
        ST_DONE
    } lcs_state_t;

endpackage

>>> rtl/core/linear_contrast_stretch_unit.sv
// load request: accepted in idle, then passes through wrap and store/update before idle takes the next request
// read request: passes through wrap, read and fetch, then the 8-step restoring divider
//   (one quotient bit per cycle) and done; the divider is skipped when the frame is flat
//   or the pixel clamps to 0 or 255
// one request at a time, next request accepted on the cycle after the previous one retires
// rst_n async active low: min 255, max 0, positions 0, frame_pixels 65536, store undefined
module linear_contrast_stretch_unit
    import lcs_pkg::*;
#(
    parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [FRAME_PIXELS_W-1:0] cfg_data,        // frame_pixels
    // request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [PIX_W-1:0]          s_axis_tdata,    // [7:0] pixel_in
    input  logic                      s_axis_tuser,    // [0] action
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [PIX_W-1:0]          m_axis_tdata,    // [7:0] pixel_out
    output logic                      m_axis_tlast
);

    // position counters hold values up to the frame size itself
    localparam int POS_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CMP_W  = (POS_W > FRAME_PIXELS_W) ? POS_W : FRAME_PIXELS_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W  = $clog2(DIV_STEPS);

    // frame store, read data registered
    logic [PIX_W-1:0] frame_mem [MAX_PIXELS];
    logic [PIX_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_addr;

    // control state
    lcs_state_t state_reg, state_next;
    logic [FRAME_PIXELS_W-1:0] frame_pixels_reg;
    logic [POS_W-1:0] load_pos_reg, load_pos_next;
    logic [POS_W-1:0] read_pos_reg, read_pos_next;
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] max_reg, max_next;
    logic             out_valid_reg, out_valid_next;

    // request and divider payload
    logic             act_reg, act_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic             last_reg, last_next;
    logic [PIX_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] num_reg, num_next;
    logic [PIX_W-1:0] dvs_reg, dvs_next;
    logic [PIX_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PIX_W-1:0] out_pix_reg, out_pix_next;
    logic             out_last_reg, out_last_next;

    // effective frame size: 0 acts as 1, anything above the store depth clips to it
    logic [CMP_W-1:0] fp_ext;
    logic [POS_W-1:0] size_c;

    // shared datapath signals
    logic [PIX_W-1:0]   diff_c;
    logic [2*PIX_W-1:0] prod_c;
    logic [PIX_W:0]     rem_shift_c;
    logic               q_bit_c;
    logic [POS_W-1:0]   load_inc_c;
    logic [POS_W-1:0]   read_inc_c;

    assign fp_ext = CMP_W'(frame_pixels_reg);

    always_comb
    begin
        if (fp_ext == '0)
        begin
            size_c = POS_W'(1);
        end
        else if (fp_ext > CMP_W'(MAX_PIXELS))
        begin
            size_c = POS_W'(MAX_PIXELS);
        end
        else
        begin
            size_c = POS_W'(fp_ext);
        end
    end

    // config register, taken on every write request
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_pixels_reg <= cfg_data;
        end
    end

    // frame store port: write on load, registered read on fetch
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= pix_reg;
        end
        rd_data_reg <= frame_mem[mem_addr];
    end

    // handshake outputs
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

    // (p - min) * 255 as (d << 8) - d
    assign diff_c = rd_data_reg - min_reg;
    assign prod_c = {diff_c, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff_c};

    // one restoring division step: shift in next numerator bit, trial subtract
    assign rem_shift_c = {rem_reg, num_reg[PIX_W-1]};
    assign q_bit_c     = (rem_shift_c >= {1'b0, dvs_reg});

    assign load_inc_c = load_pos_reg + POS_W'(1);
    assign read_inc_c = read_pos_reg + POS_W'(1);

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_pos_reg  <= '0;
            read_pos_reg  <= '0;
            min_reg       <= LEVEL_MAX;
            max_reg       <= LEVEL_MIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            read_pos_reg  <= read_pos_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pix_reg      <= pix_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        dvs_reg      <= dvs_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        load_pos_next  = load_pos_reg;
        read_pos_next  = read_pos_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        act_next       = act_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_addr       = read_pos_reg[ADDR_W-1:0];

        // result leaves the output register
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tuser;
                    pix_next   = s_axis_tdata;
                    state_next = ST_WRAP;
                end
            end

            // a smaller frame size may have been written since the last request
            ST_WRAP:
            begin
                if (load_pos_reg >= size_c)
                begin
                    load_pos_next = '0;
                end
                if (read_pos_reg >= size_c)
                begin
                    read_pos_next = '0;
                end
                state_next = (act_reg == ACT_LOAD) ? ST_LOAD : ST_READ;
            end

            ST_LOAD:
            begin
                mem_we   = 1'b1;
                mem_addr = load_pos_reg[ADDR_W-1:0];
                if (load_pos_reg == '0)
                begin
                    // first pixel of a new frame restarts the range and the readout
                    min_next      = pix_reg;
                    max_next      = pix_reg;
                    read_pos_next = '0;
                end
                else
                begin
                    if (pix_reg < min_reg)
                    begin
                        min_next = pix_reg;
                    end
                    if (pix_reg > max_reg)
                    begin
                        max_next = pix_reg;
                    end
                end
                load_pos_next = (load_inc_c >= size_c) ? '0 : load_inc_c;
                state_next    = ST_IDLE;
            end

            ST_READ:
            begin
                mem_addr      = read_pos_reg[ADDR_W-1:0];
                last_next     = (read_inc_c >= size_c);
                read_pos_next = (read_inc_c >= size_c) ? '0 : read_inc_c;
                state_next    = ST_FETCH;
            end

            ST_FETCH:
            begin
                if (max_reg <= min_reg || rd_data_reg <= min_reg)
                begin
                    // flat frame or pixel at or below the minimum
                    quo_next   = LEVEL_MIN;
                    state_next = ST_DONE;
                end
                else if (rd_data_reg >= max_reg)
                begin
                    quo_next   = LEVEL_MAX;
                    state_next = ST_DONE;
                end
                else
                begin
                    // quotient fits in 8 bits, so the high byte is already below the divisor
                    rem_next   = prod_c[2*PIX_W-1:PIX_W];
                    num_next   = prod_c[PIX_W-1:0];
                    dvs_next   = max_reg - min_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = q_bit_c ? PIX_W'(rem_shift_c - {1'b0, dvs_reg})
                                   : rem_shift_c[PIX_W-1:0];
                num_next = {num_reg[PIX_W-2:0], 1'b0};
                quo_next = {quo_reg[PIX_W-2:0], q_bit_c};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            // wait for room in the output register
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = quo_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/lcs_checker.sv
module lcs_port_props
    import lcs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [PIX_W-1:0]          m_axis_tdata,
    input logic                      m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // one request at a time: busy right after an accepted request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // no result appears the cycle after a request is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result too early");

    // config channel never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind linear_contrast_stretch_unit lcs_port_props u_lcs_port_props (.*);

>>> tb/lcs_checker.sv
module lcs_checker
    import lcs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [FRAME_PIXELS_W-1:0] cfg_data,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [PIX_W-1:0]          s_axis_tdata,
    input  logic                      s_axis_tuser,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [PIX_W-1:0]          m_axis_tdata,
    input  logic                      m_axis_tlast,
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_checked,
    output int                        lasts_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEFAULT_MAX_PIXELS;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             last;
    } stretched_t;

    logic [PIX_W-1:0]          frame_copy [DEPTH];
    logic [FRAME_PIXELS_W-1:0] size_reg;
    logic [PIX_W-1:0]          lo_level;
    logic [PIX_W-1:0]          hi_level;
    int unsigned               wr_pos;
    int unsigned               rd_pos;
    stretched_t                stretched_q [$];

    function automatic int unsigned frame_span(input logic [FRAME_PIXELS_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] p);
        int unsigned num;
        int unsigned den;
        if (hi_level <= lo_level || p <= lo_level)
            return LEVEL_MIN;
        if (p >= hi_level)
            return LEVEL_MAX;
        num = (int'(p) - int'(lo_level)) * int'(LEVEL_MAX);
        den = int'(hi_level) - int'(lo_level);
        return PIX_W'(num / den);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic predict_request(input logic act, input logic [PIX_W-1:0] pix);
        int unsigned span;
        stretched_t  want;
        span = frame_span(size_reg);
        if (wr_pos >= span)
            wr_pos = 0;
        if (rd_pos >= span)
            rd_pos = 0;
        if (act == ACT_LOAD)
        begin
            // first pixel of a frame restarts the level range
            if (wr_pos == 0)
            begin
                lo_level = LEVEL_MAX;
                hi_level = LEVEL_MIN;
                rd_pos   = 0;
            end
            frame_copy[wr_pos] = pix;
            if (pix < lo_level)
                lo_level = pix;
            if (pix > hi_level)
                hi_level = pix;
            wr_pos++;
            if (wr_pos >= span)
                wr_pos = 0;
        end
        else
        begin
            want.last  = (rd_pos + 1 >= span);
            want.level = stretch_level(frame_copy[rd_pos]);
            stretched_q.push_back(want);
            rd_pos++;
            if (rd_pos >= span)
                rd_pos = 0;
        end
    endtask

    task automatic check_result(input logic [PIX_W-1:0] level, input logic last);
        stretched_t want;
        if (stretched_q.size() == 0)
        begin
            report_mismatch($sformatf("result %0d last %0b with nothing expected", level, last));
            return;
        end
        want = stretched_q.pop_front();
        results_checked++;
        if (want.last)
            lasts_checked++;
        if (level !== want.level)
            report_mismatch($sformatf("pixel_out %0d, expected %0d", level, want.level));
        if (last !== want.last)
            report_mismatch($sformatf("tlast %0b, expected %0b", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = FRAME_PIXELS_RESET;
            lo_level = LEVEL_MAX;
            hi_level = LEVEL_MIN;
            wr_pos   = 0;
            rd_pos   = 0;
            stretched_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tlast);
            outstanding <= stretched_q.size();
        end
    end

endmodule

>>> tb/linear_contrast_stretch_unit_tb.sv
module linear_contrast_stretch_unit_tb;
    import lcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = DEFAULT_MAX_PIXELS;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_TARGET  = 1600;
    // a load passes through wrap and store/update and leaves no result behind
    localparam int LOAD_SETTLE    = 16;
    localparam int TAIL_WAIT      = 40;
    localparam int LONG_HOLD      = 300;
    localparam int FULL_FRAME_MAX = 64;

    // how the pixels of one generated frame are spread over the grey levels
    typedef enum int {
        SHAPE_ANY,
        SHAPE_NARROW,
        SHAPE_FLAT,
        SHAPE_EXTREME
    } level_shape_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [FRAME_PIXELS_W-1:0] cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [PIX_W-1:0]          s_axis_tdata  = '0;    // [7:0] pixel_in
    logic                      s_axis_tuser  = 1'b0;  // [0] action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [PIX_W-1:0]          m_axis_tdata;          // [7:0] pixel_out
    logic                      m_axis_tlast;

    int mismatches;
    int outstanding;
    int results_checked;
    int lasts_checked;

    // stimulus-side view of the frame positions, so that no read ever
    // reaches a store entry that was never loaded
    bit          ever_written [DEPTH];
    int unsigned active_span = DEPTH;
    int unsigned track_wr    = 0;
    int unsigned track_rd    = 0;

    int loads_sent   = 0;
    int reads_sent   = 0;
    int sizes_tried  = 0;
    int holds_done   = 0;
    int cycle_count  = 0;
    int sink_hold_len = 0;  // set by the stimulus, served by the sink process
    bit steady       = 1'b0;  // no random gaps or stalls on either side while set

    always #6 clk = ~clk;

    linear_contrast_stretch_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // watches all three channels, predicts and compares
    lcs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .lasts_checked   (lasts_checked)
    );

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // frame size as the block applies it: 0 acts as 1, oversize clamps
    function automatic int unsigned span_of(input logic [FRAME_PIXELS_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return v;
    endfunction

    function automatic bit next_read_written();
        int unsigned r;
        r = (track_rd >= active_span) ? 0 : track_rd;
        return ever_written[r];
    endfunction

    // mostly small frames so that whole frames and tlast come often
    function automatic logic [FRAME_PIXELS_W-1:0] pick_frame_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return FRAME_PIXELS_W'($urandom_range(2, 48));
        if (r < 65)
            return FRAME_PIXELS_W'(1);
        if (r < 70)
            return '0;
        if (r < 75)
            return FRAME_PIXELS_W'(DEPTH);
        if (r < 80)
            return '1;
        if (r < 85)
            return FRAME_PIXELS_W'($urandom_range(DEPTH + 1, 131071));
        return FRAME_PIXELS_W'($urandom_range(49, 2000));
    endfunction

    function automatic logic [PIX_W-1:0] pick_level(input level_shape_t shape,
                                                    input logic [PIX_W-1:0] base);
        int v;
        case (shape)
            SHAPE_NARROW:
            begin
                v = int'(base) + $urandom_range(0, 3);
                return (v > int'(LEVEL_MAX)) ? LEVEL_MAX : PIX_W'(v);
            end
            SHAPE_FLAT:    return base;
            SHAPE_EXTREME: return $urandom_range(0, 1) ? LEVEL_MAX : LEVEL_MIN;
            default:       return PIX_W'($urandom);
        endcase
    endfunction

    // present one request and hold it until the block takes it; valid stays
    // high into the next request when no gap follows
    task automatic offer_request(input logic act, input logic [PIX_W-1:0] pix);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // advance the position tracker, then send
    task automatic issue(input logic act, input logic [PIX_W-1:0] pix);
        if (track_wr >= active_span)
            track_wr = 0;
        if (track_rd >= active_span)
            track_rd = 0;
        if (act == ACT_LOAD)
        begin
            if (track_wr == 0)
                track_rd = 0;
            ever_written[track_wr] = 1'b1;
            track_wr++;
            if (track_wr >= active_span)
                track_wr = 0;
            loads_sent++;
        end
        else
        begin
            track_rd++;
            if (track_rd >= active_span)
                track_rd = 0;
            reads_sent++;
        end
        offer_request(act, pix);
    endtask

    // reads stop early rather than touch a never-loaded entry
    task automatic read_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (!next_read_written())
                break;
            issue(ACT_READ, PIX_W'($urandom));
        end
    endtask

    // sender pause: nothing offered until every stretched pixel is back
    // and any load still in flight has retired
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [FRAME_PIXELS_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        active_span = span_of(v);
        sizes_tried++;
    endtask

    // result side: random stalls, plus long hold-offs on request from the
    // stimulus, counted here so the sender keeps offering meanwhile
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_len) @(posedge clk);
                sink_hold_len = 0;
                holds_done++;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 35)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                             : $urandom_range(1, 4);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results still due",
                 cycle_count, outstanding);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int           goal;
        int           frames;
        int           n;
        int           start_pos;
        level_shape_t shape;
        logic [PIX_W-1:0] base;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset frame size: both extremes and a mid level, no tlast yet
        issue(ACT_LOAD, LEVEL_MIN);
        issue(ACT_LOAD, LEVEL_MAX);
        issue(ACT_LOAD, 8'd128);
        issue(ACT_LOAD, 8'd1);
        read_pixels(4);

        // one-pixel frames are always flat and always carry tlast
        set_frame_size(FRAME_PIXELS_W'(1));
        issue(ACT_LOAD, 8'd200);
        read_pixels(1);
        // size 0 behaves as 1, and the old positions wrap
        set_frame_size('0);
        issue(ACT_LOAD, 8'd9);
        read_pixels(1);

        // full four-pixel frame, tlast on the fourth read
        set_frame_size(FRAME_PIXELS_W'(4));
        issue(ACT_LOAD, LEVEL_MIN);
        issue(ACT_LOAD, LEVEL_MAX);
        issue(ACT_LOAD, 8'd128);
        issue(ACT_LOAD, 8'd1);
        read_pixels(4);

        // short new frame: the two stale entries fall above and below the
        // new range; receiver holds off while the reads keep coming
        issue(ACT_LOAD, 8'd100);
        issue(ACT_LOAD, 8'd110);
        sink_hold_len = LONG_HOLD;
        read_pixels(4);

        // random phases, each under its own frame size
        goal = loads_sent + reads_sent + RANDOM_TARGET;
        while (loads_sent + reads_sent < goal)
        begin
            set_frame_size(pick_frame_size());
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
                sink_hold_len = $urandom_range(100, LONG_HOLD);
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++)
            begin
                shape = level_shape_t'($urandom_range(0, 3));
                base  = PIX_W'($urandom);
                if ($urandom_range(0, 4) != 0)
                begin
                    // well-formed: finish the frame being loaded, read it back
                    if (active_span <= FULL_FRAME_MAX)
                    begin
                        start_pos = (track_wr >= active_span) ? 0 : track_wr;
                        n = active_span - start_pos;
                        for (int i = 0; i < n; i++)
                            issue(ACT_LOAD, pick_level(shape, base));
                        read_pixels(active_span + $urandom_range(0, 2));
                    end
                    else
                    begin
                        n = $urandom_range(1, 40);
                        for (int i = 0; i < n; i++)
                            issue(ACT_LOAD, pick_level(shape, base));
                        read_pixels($urandom_range(1, n + 2));
                    end
                end
                else
                begin
                    // noise: loads and reads mixed at random
                    n = $urandom_range(4, 30);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 1) && next_read_written())
                            issue(ACT_READ, PIX_W'($urandom));
                        else
                            issue(ACT_LOAD, PIX_W'($urandom));
                    end
                end
            end
        end

        steady = 1'b0;
        settle();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("sent %0d pixel loads and %0d reads under %0d frame sizes, %0d long hold-offs",
                 loads_sent, reads_sent, sizes_tried, holds_done);
        $display("compared %0d stretched pixels, %0d of them frame-final, %0d mismatches",
                 results_checked, lasts_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
